FILE: hdl/orbit_camera_zoom_step_defines.svh
// Assertion macros for the orbit camera zoom step.
`ifndef ORBIT_CAMERA_ZOOM_STEP_DEFINES_SVH
`define ORBIT_CAMERA_ZOOM_STEP_DEFINES_SVH
`ifndef SYNTH
`define OCZ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OCZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OCZ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OCZ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/ocz_pkg.sv
`default_nettype none
package ocz_pkg;
  localparam int SINE_TABLE_BITS = 10;
  localparam int QTAB_BITS = SINE_TABLE_BITS - 2;
  localparam int QTAB_N = 1 << QTAB_BITS;

  localparam logic [2:0] REG_MIN_RADIUS    = 3'd0;
  localparam logic [2:0] REG_MAX_RADIUS    = 3'd1;
  localparam logic [2:0] REG_START_RADIUS  = 3'd2;
  localparam logic [2:0] REG_HEIGHT_OFFSET = 3'd3;
  localparam logic [2:0] REG_ZOOM_RATE     = 3'd4;
  localparam logic [2:0] REG_FAST_GAIN     = 3'd5;
  localparam logic [2:0] REG_SLOW_GAIN     = 3'd6;
  localparam logic [2:0] REG_STICK_GAIN    = 3'd7;

  // Datapath steps issued by the controller; OP_NONE does nothing.
  typedef enum logic [3:0] {
    OP_LOAD   = 4'd0,
    OP_DEMAND = 4'd1,
    OP_VEL    = 4'd2,
    OP_RADIUS = 4'd3,
    OP_HORIZ  = 4'd4,
    OP_VERT   = 4'd5,
    OP_PX     = 4'd6,
    OP_PZ     = 4'd7,
    OP_OUT    = 4'd8,
    OP_NONE   = 4'd9
  } op_t;

  typedef struct packed {
    op_t  op;
  } dp_cmd_t;

  typedef logic [QTAB_N-1:0][14:0] qtab_t;

  // Polynomial sine magnitude over the first quarter turn.
  function automatic logic [14:0] poly_mag(input logic [14:0] x);
    logic [31:0] t, t2, prod, inner, mid, mag;
    t = {16'd0, x, 1'b0};
    t2 = (t * t) >> 15;
    prod = (t2 * 32'd2320) >> 15;
    inner = 32'd21024 - prod;
    prod = (t2 * inner) >> 15;
    mid = 32'd51472 - prod;
    mag = (t * mid) >> 15;
    if (mag > 32'd32767) mag = 32'd32767;
    poly_mag = mag[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int i = 0; i < QTAB_N; i++) begin
      tab[i] = poly_mag(15'(i << (16 - SINE_TABLE_BITS)));
    end
    return tab;
  endfunction

  localparam qtab_t QSIN = build_qtab();

  // Quarter-wave table lookup; the full quarter point saturates to 32767.
  function automatic logic signed [16:0] sine_q15(input logic [15:0] ang);
    logic [QTAB_BITS-1:0] idx, ridx;
    logic [14:0] mag;
    idx = ang[13 -: QTAB_BITS];
    ridx = ~idx + 1'b1;
    if (!ang[14]) mag = QSIN[idx];
    else if (idx == '0) mag = 15'd32767;
    else mag = QSIN[ridx];
    sine_q15 = ang[15] ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
  endfunction
endpackage
`default_nettype wire

FILE: hdl/ocz_ctrl.sv
`default_nettype none
`include "orbit_camera_zoom_step_defines.svh"
module ocz_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            exit_in,
  input  wire logic            out_busy,
  output ocz_pkg::dp_cmd_t     cmd,
  output logic                 in_ready,
  output logic                 out_load
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DEMAND = 11'b00000000010,
    S_VEL    = 11'b00000000100,
    S_RADIUS = 11'b00000001000,
    S_HORIZ  = 11'b00000010000,
    S_VERT   = 11'b00000100000,
    S_PX     = 11'b00001000000,
    S_PZ     = 11'b00010000000,
    S_OUT    = 11'b00100000000,
    S_WAIT   = 11'b01000000000,
    S_EXIT   = 11'b10000000000
  } state_t;
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op = ocz_pkg::OP_NONE;
    out_load = 1'b0;
    in_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op = ocz_pkg::OP_LOAD;
          state_nxt = exit_in ? S_EXIT : S_DEMAND;
        end
      end
      S_DEMAND: begin cmd.op = ocz_pkg::OP_DEMAND; state_nxt = S_VEL; end
      S_VEL:    begin cmd.op = ocz_pkg::OP_VEL;    state_nxt = S_RADIUS; end
      S_RADIUS: begin cmd.op = ocz_pkg::OP_RADIUS; state_nxt = S_HORIZ; end
      S_HORIZ:  begin cmd.op = ocz_pkg::OP_HORIZ;  state_nxt = S_VERT; end
      S_VERT:   begin cmd.op = ocz_pkg::OP_VERT;   state_nxt = S_PX; end
      S_PX:     begin cmd.op = ocz_pkg::OP_PX;     state_nxt = S_PZ; end
      S_PZ:     begin cmd.op = ocz_pkg::OP_PZ;     state_nxt = S_OUT; end
      S_OUT:    begin cmd.op = ocz_pkg::OP_OUT;    state_nxt = S_WAIT; end
      S_WAIT, S_EXIT: begin
        if (!out_busy) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `OCZ_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `OCZ_ASSERT_NEXT(a_load_idle, clk, rst_n, out_load, state_r == S_IDLE)
  `OCZ_ASSERT_NEXT(a_exit_path, clk, rst_n, in_fire && exit_in, state_r == S_EXIT)
endmodule
`default_nettype wire

FILE: hdl/ocz_datapath.sv
`default_nettype none
module ocz_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  ocz_pkg::dp_cmd_t         cmd,
  input  wire logic                in_zin,
  input  wire logic                in_zout,
  input  wire logic signed [7:0]   in_sx,
  input  wire logic signed [7:0]   in_sy,
  input  wire logic signed [31:0]  in_tx,
  input  wire logic signed [31:0]  in_ty,
  input  wire logic signed [31:0]  in_tz,
  input  wire logic                cfg_fire,
  input  wire logic [2:0]          cfg_idx,
  input  wire logic [19:0]         cfg_val,
  output logic signed [31:0]       cam_x,
  output logic signed [31:0]       cam_y,
  output logic signed [31:0]       cam_z,
  output logic [15:0]              yaw,
  output logic [15:0]              pitch
);
  logic [18:0] min_r_r, max_r_r;
  logic signed [19:0] hoff_r;
  logic [15:0] rate_r, fgain_r, sgain_r;
  logic [3:0] sgain4_r;

  logic zin_r, zout_r;
  logic signed [7:0] sx_r, sy_r;
  logic signed [31:0] tx_r, ty_r, tz_r;
  logic [18:0] radius_r, radius_nxt;
  logic signed [16:0] vel_r, vel_nxt;
  logic [15:0] yaw_r, pitch_r;
  logic signed [19:0] demand_r;
  logic signed [35:0] h_r, vy_r, px_r, pz_r;
  logic signed [31:0] cx_r, cy_r, cz_r;

  // There is no start radius register: reset loads a fixed radius, and a write to that index has no effect.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r_r <= 19'd5120; max_r_r <= 19'd512000;
      hoff_r <= 20'sd5120; rate_r <= 16'd2621; fgain_r <= 16'd19661;
      sgain_r <= 16'd5243; sgain4_r <= 4'd3;
    end else if (cfg_fire) begin
      case (cfg_idx)
        ocz_pkg::REG_MIN_RADIUS:    min_r_r <= cfg_val[18:0];
        ocz_pkg::REG_MAX_RADIUS:    max_r_r <= cfg_val[18:0];
        ocz_pkg::REG_START_RADIUS:  ;
        ocz_pkg::REG_HEIGHT_OFFSET: hoff_r <= $signed(cfg_val);
        ocz_pkg::REG_ZOOM_RATE:     rate_r <= cfg_val[15:0];
        ocz_pkg::REG_FAST_GAIN:     fgain_r <= cfg_val[15:0];
        ocz_pkg::REG_SLOW_GAIN:     sgain_r <= cfg_val[15:0];
        ocz_pkg::REG_STICK_GAIN:    sgain4_r <= cfg_val[3:0];
        default: ;
      endcase
    end
  end

  // Demand, velocity and radius step arithmetic.
  logic [34:0] dprod;
  logic [16:0] avel;
  logic [18:0] adem;
  logic signed [20:0] diff;
  logic [15:0] gain;
  logic signed [37:0] gprod;
  logic [37:0] gmag;
  logic signed [38:0] gstep;
  logic signed [39:0] vsum;
  logic signed [20:0] rsum;
  logic [18:0] rclamp;
  always_comb begin
    dprod = {3'd0, rate_r} * {16'd0, radius_r};
    avel = vel_r[16] ? 17'(-vel_r) : 17'(vel_r);
    adem = demand_r[19] ? 19'(-demand_r) : 19'(demand_r);
    gain = ({2'b0, avel} > adem) ? fgain_r : sgain_r;
    diff = 21'(demand_r) - 21'(vel_r);
    gprod = $signed({1'b0, gain}) * diff;
    gmag = gprod[37] ? 38'(-gprod) : 38'(gprod);
    gmag = (gmag + 38'd32768) >> 16;
    gstep = gprod[37] ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
    vsum = 40'(vel_r) + 40'(gstep);
    if (vsum < -40'sd65536) vel_nxt = -17'sd65536;
    else if (vsum > 40'sd65535) vel_nxt = 17'sd65535;
    else vel_nxt = vsum[16:0];
    rsum = $signed({2'b0, radius_r}) + 21'(vel_r);
    if (rsum < 0) rclamp = '0;
    else if (rsum > 21'sd524287) rclamp = 19'h7FFFF;
    else rclamp = rsum[18:0];
    if (rclamp < min_r_r) rclamp = min_r_r;
    if (rclamp > max_r_r) rclamp = max_r_r;
    radius_nxt = rclamp;
  end

  // Shared multiplier with rounding.
  logic signed [35:0] ma;
  logic signed [16:0] mb;
  logic signed [52:0] mprod;
  logic [52:0] mmag;
  logic signed [35:0] mround;
  always_comb begin
    ma = 36'(h_r);
    mb = ocz_pkg::sine_q15(yaw_r);
    case (cmd.op)
      ocz_pkg::OP_HORIZ: begin
        ma = $signed({17'd0, radius_r}); mb = ocz_pkg::sine_q15(pitch_r + 16'h4000);
      end
      ocz_pkg::OP_VERT: begin
        ma = $signed({17'd0, radius_r}); mb = ocz_pkg::sine_q15(pitch_r);
      end
      ocz_pkg::OP_PZ: mb = ocz_pkg::sine_q15(yaw_r - 16'h4000);
      default: ;
    endcase
    mprod = 53'(ma) * 53'(mb);
    mmag = mprod[52] ? 53'(-mprod) : 53'(mprod);
    mmag = (mmag + 53'd16384) >> 15;
    mround = mprod[52] ? -$signed(mmag[35:0]) : $signed(mmag[35:0]);
  end

  function automatic logic signed [31:0] sat(input logic signed [37:0] v);
    if (v > 38'sd2147483647) sat = 32'h7FFFFFFF;
    else if (v < -38'sd2147483648) sat = 32'h80000000;
    else sat = v[31:0];
  endfunction

  logic signed [15:0] dyaw, dpitch;
  assign dyaw = $signed({{8{sx_r[7]}}, sx_r}) * $signed({12'd0, sgain4_r});
  assign dpitch = $signed({{8{sy_r[7]}}, sy_r}) * $signed({12'd0, sgain4_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 19'd12800; vel_r <= '0; yaw_r <= '0; pitch_r <= '0;
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
    end else begin
      case (cmd.op)
        ocz_pkg::OP_LOAD: begin
          zin_r <= in_zin; zout_r <= in_zout; sx_r <= in_sx; sy_r <= in_sy;
          tx_r <= in_tx; ty_r <= in_ty; tz_r <= in_tz;
        end
        ocz_pkg::OP_DEMAND: begin
          demand_r <= zout_r ? $signed({1'b0, dprod[34:16]})
                    : (zin_r ? -$signed({1'b0, dprod[34:16]}) : 20'sd0);
          yaw_r <= yaw_r - dyaw;
          pitch_r <= pitch_r + dpitch;
        end
        ocz_pkg::OP_VEL: vel_r <= vel_nxt;
        ocz_pkg::OP_RADIUS: radius_r <= radius_nxt;
        ocz_pkg::OP_HORIZ: h_r <= mround;
        ocz_pkg::OP_VERT: vy_r <= mround;
        ocz_pkg::OP_PX: px_r <= mround;
        ocz_pkg::OP_PZ: pz_r <= mround;
        ocz_pkg::OP_OUT: begin
          cx_r <= sat(38'(tx_r) + 38'(px_r));
          cy_r <= sat(38'(ty_r) + 38'(hoff_r) + 38'(vy_r));
          cz_r <= sat(38'(tz_r) + 38'(pz_r));
        end
        default: ;
      endcase
    end
  end

  assign cam_x = cx_r;
  assign cam_y = cy_r;
  assign cam_z = cz_r;
  assign yaw = yaw_r;
  assign pitch = pitch_r;
endmodule
`default_nettype wire

FILE: hdl/orbit_camera_zoom_step.sv
// Orbit camera zoom step: one input transfer per frame tick, one result transfer each.
// Input channel in_*: buttons, stick values and target position in in_tdata.
// Configuration channel cfg_*: register index and write data, accepted only while
// the input side is ready, so never while an item is being computed.
// Result channel out_*: exit flag, camera position and the two angles in out_tdata.
// An ordinary item goes from input transfer to a valid result through eight
// sequenced steps (demand, velocity, radius, four rounded products through one
// shared multiplier, output sums) and the output load. An exit item goes straight
// to the output load. One item is in work at a time: the next input transfer waits
// until the output load, which an output stall delays. The result sits in an output
// register; while it waits, the next input transfer is accepted and computed, then
// waits for the register.
// A synchronous active-low reset restores the registers, loads the start radius,
// clears velocity, angles and held position, and empties the output register.
// A stalled receiver holds out_tdata steady and stops further input transfers
// once the next result is ready.
`default_nettype none
`include "orbit_camera_zoom_step_defines.svh"
module orbit_camera_zoom_step (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // exit_pressed, zoom_in_held, zoom_out_held, stick_x[8], stick_y[8],
  // target_x[32], target_y[32], target_z[32], zero pad to 120 bits
  input  wire logic [119:0] in_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [19:0]  cfg_data,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // exit_request, cam_x[32], cam_y[32], cam_z[32], yaw_angle[16],
  // pitch_angle[16], zero pad to 136 bits
  output logic [135:0]      out_tdata
);
  ocz_pkg::dp_cmd_t cmd;
  logic in_fire, out_load, exit_r;
  logic out_valid_r;
  logic [135:0] out_data_r;
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [15:0] yaw, pitch;

  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = in_tready;

  ocz_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .exit_in(in_tdata[0]),
    .out_busy(out_valid_r && !out_tready), .cmd(cmd), .in_ready(in_tready),
    .out_load(out_load)
  );

  ocz_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_zin(in_tdata[1]), .in_zout(in_tdata[2]),
    .in_sx(in_tdata[10:3]), .in_sy(in_tdata[18:11]),
    .in_tx(in_tdata[50:19]), .in_ty(in_tdata[82:51]), .in_tz(in_tdata[114:83]),
    .cfg_fire(cfg_valid && cfg_ready), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .cam_x(cam_x), .cam_y(cam_y), .cam_z(cam_z), .yaw(yaw), .pitch(pitch)
  );

  always_ff @(posedge clk) begin
    if (in_fire) exit_r <= in_tdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {7'd0, pitch, yaw, cam_z, cam_y, cam_x, exit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

  `OCZ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_tready,
    out_valid_r && $stable(out_data_r))
  `OCZ_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_load, !(out_valid_r && !out_tready))
endmodule
`default_nettype wire

FILE: sim/tb_orbit_camera_zoom_step.sv
`timescale 1ns / 1ps
module tb_orbit_camera_zoom_step;

  typedef struct packed {
    logic [31:0] tz;
    logic [31:0] ty;
    logic [31:0] tx;
    logic [7:0]  stick_y;
    logic [7:0]  stick_x;
    logic        zoom_out;
    logic        zoom_in;
    logic        exit_pressed;
  } frame_t;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [31:0] cam_z;
    logic [31:0] cam_y;
    logic [31:0] cam_x;
    logic        exit_request;
  } view_t;

  typedef struct {
    logic [2:0]  idx;
    logic [19:0] val;
  } cfg_wr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] in_tdata = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;

  orbit_camera_zoom_step DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Camera model state and register copy.
  longint r_min, r_max, r_start, h_off, z_rate, g_fast, g_slow, s_gain;
  longint cam_radius, cam_vel;
  logic [15:0] cam_yaw, cam_pitch;
  longint held_pos [3];

  frame_t frame_q [$];
  view_t  view_q [$];
  cfg_wr_t cfg_q [$];
  int idle_pct = 0, stall_pct = 0;
  bit hold_out = 0;
  int errors = 0, n_views = 0, n_exits = 0, quiet = 0;

  function automatic longint rnd_shift(longint p, int sh);
    longint m;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 << (sh - 1))) >>> sh;
    return (p < 0) ? -m : m;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sin_q15(logic [15:0] ang);
    logic [15:0] a;
    longint x, t, t2, inner, mid, mag;
    a = ang & ~((16'd1 << (16 - ocz_pkg::SINE_TABLE_BITS)) - 16'd1);
    x = a[13:0];
    if (a[14]) x = 16384 - x;
    t = x * 2;
    t2 = (t * t) >>> 15;
    inner = 21024 - ((t2 * 2320) >>> 15);
    mid = 51472 - ((t2 * inner) >>> 15);
    mag = (t * mid) >>> 15;
    if (mag > 32767) mag = 32767;
    return a[15] ? -mag : mag;
  endfunction

  task automatic model_reset();
    r_min = 5120; r_max = 512000; r_start = 12800; h_off = 5120;
    z_rate = 2621; g_fast = 19661; g_slow = 5243; s_gain = 3;
    cam_radius = r_start; cam_vel = 0; cam_yaw = 0; cam_pitch = 0;
    held_pos = '{0, 0, 0};
  endtask

  task automatic model_config(logic [2:0] idx, logic [19:0] v);
    case (idx)
      ocz_pkg::REG_MIN_RADIUS:    r_min = v[18:0];
      ocz_pkg::REG_MAX_RADIUS:    r_max = v[18:0];
      ocz_pkg::REG_START_RADIUS:  r_start = v[18:0];
      ocz_pkg::REG_HEIGHT_OFFSET: h_off = $signed(v);
      ocz_pkg::REG_ZOOM_RATE:     z_rate = v[15:0];
      ocz_pkg::REG_FAST_GAIN:     g_fast = v[15:0];
      ocz_pkg::REG_SLOW_GAIN:     g_slow = v[15:0];
      ocz_pkg::REG_STICK_GAIN:    s_gain = v[3:0];
      default: ;
    endcase
  endtask

  function automatic view_t orbit_step(frame_t f);
    view_t o;
    longint dmag, dem, gain, v, r, h, vy, px, pz;
    if (!f.exit_pressed) begin
      dmag = (z_rate * cam_radius) >>> 16;
      dem = f.zoom_out ? dmag : (f.zoom_in ? -dmag : 0);
      gain = (((cam_vel < 0) ? -cam_vel : cam_vel) > dmag * (dem != 0)) ? g_fast : g_slow;
      v = cam_vel + rnd_shift(gain * (dem - cam_vel), 16);
      if (v < -65536) v = -65536;
      if (v > 65535) v = 65535;
      cam_vel = v;
      r = cam_radius + cam_vel;
      if (r < 0) r = 0;
      if (r > 524287) r = 524287;
      if (r < r_min) r = r_min;
      if (r > r_max) r = r_max;
      cam_radius = r;
      cam_yaw = cam_yaw - 16'($signed(f.stick_x) * s_gain);
      cam_pitch = cam_pitch + 16'($signed(f.stick_y) * s_gain);
      h = rnd_shift(cam_radius * sin_q15(cam_pitch + 16'h4000), 15);
      vy = rnd_shift(cam_radius * sin_q15(cam_pitch), 15);
      px = rnd_shift(h * sin_q15(cam_yaw), 15);
      pz = rnd_shift(h * sin_q15(cam_yaw - 16'h4000), 15);
      held_pos[0] = sat32(longint'($signed(f.tx)) + px);
      held_pos[1] = sat32(longint'($signed(f.ty)) + h_off + vy);
      held_pos[2] = sat32(longint'($signed(f.tz)) + pz);
    end
    o.exit_request = f.exit_pressed;
    o.cam_x = held_pos[0][31:0];
    o.cam_y = held_pos[1][31:0];
    o.cam_z = held_pos[2][31:0];
    o.yaw = cam_yaw;
    o.pitch = cam_pitch;
    return o;
  endfunction

  // Input and configuration driver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (frame_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {5'd0, frame_q[0]};
          view_q.push_back(orbit_step(frame_q.pop_front()));
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      if (!cfg_valid || cfg_ready) begin
        if (cfg_q.size() > 0) begin
          cfg_valid <= 1'b1;
          cfg_index <= cfg_q[0].idx;
          cfg_data <= cfg_q[0].val;
          model_config(cfg_q[0].idx, cfg_q[0].val);
          void'(cfg_q.pop_front());
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    view_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (cfg_valid && cfg_ready)
          || (out_tvalid && out_tready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[128:0];
        if (view_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = view_q.pop_front();
          n_views++;
          if (want.exit_request) n_exits++;
          if (got !== want || out_tdata[135:129] !== '0) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, out_tdata);
            errors++;
          end
        end
      end
      out_tready <= !hold_out && ($urandom_range(99) >= stall_pct);
      if (quiet > 20000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic frame_t rand_frame(int exit_pct);
    frame_t f;
    f = 115'({$urandom, $urandom, $urandom, $urandom});
    f.exit_pressed = ($urandom_range(99) < exit_pct);
    if ($urandom_range(3) == 0) begin
      f.tx = $urandom_range(1) ? 32'h7fff_0000 + $urandom_range(65535) : $urandom;
      f.ty = $urandom_range(1) ? 32'h8000_ffff - $urandom_range(65535) : $urandom;
    end
    return f;
  endfunction

  task automatic drain();
    while (frame_q.size() > 0 || view_q.size() > 0 || in_tvalid || cfg_valid
           || cfg_q.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [19:0] v);
    cfg_q.push_back('{idx, v});
    drain();
  endtask

  task automatic run_phase(int n, int idle, int stall, int exit_pct);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) frame_q.push_back(rand_frame(exit_pct));
    drain();
  endtask

  initial begin
    frame_t f;
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames: exit right after reset, extremes, both buttons.
    f = '0; f.exit_pressed = 1'b1; f.zoom_out = 1'b1; frame_q.push_back(f);
    f = '1; f.exit_pressed = 1'b0; frame_q.push_back(f);
    f = '0; f.zoom_in = 1'b1; f.zoom_out = 1'b1; f.stick_x = 8'h80; f.stick_y = 8'h7f;
    f.tx = 32'h7fff_ffff; f.ty = 32'h7fff_ffff; f.tz = 32'h8000_0000; frame_q.push_back(f);
    f.stick_x = 8'h7f; f.stick_y = 8'h80; f.tx = 32'h8000_0000; f.ty = 32'h8000_0000;
    f.tz = 32'h7fff_ffff; frame_q.push_back(f);
    for (int i = 0; i < 12; i++) begin
      f = '0; f.zoom_in = (i < 6); f.stick_x = 8'h55; f.stick_y = 8'haa;
      frame_q.push_back(f);
    end
    f.exit_pressed = 1'b1; frame_q.push_back(f);
    drain();

    run_phase(300, 0, 0, 5);
    write_cfg(ocz_pkg::REG_MAX_RADIUS, 20'h7ffff);
    write_cfg(ocz_pkg::REG_ZOOM_RATE, 20'hffff);
    write_cfg(ocz_pkg::REG_FAST_GAIN, 20'hffff);
    write_cfg(ocz_pkg::REG_SLOW_GAIN, 20'hffff);
    write_cfg(ocz_pkg::REG_STICK_GAIN, 20'hf);
    write_cfg(ocz_pkg::REG_HEIGHT_OFFSET, 20'h7ffff);
    write_cfg(ocz_pkg::REG_MIN_RADIUS, 20'd0);
    write_cfg(ocz_pkg::REG_START_RADIUS, 20'h7ffff);
    run_phase(300, 77, 0, 5);

    // Long receiver hold-off while the sender keeps offering frames.
    hold_out = 1;
    for (int i = 0; i < 20; i++) frame_q.push_back(rand_frame(5));
    repeat (400) @(posedge clk);
    hold_out = 0;
    drain();

    write_cfg(ocz_pkg::REG_MIN_RADIUS, 20'h7ffff);
    write_cfg(ocz_pkg::REG_MAX_RADIUS, 20'd1000);
    write_cfg(ocz_pkg::REG_HEIGHT_OFFSET, 20'h80000);
    write_cfg(ocz_pkg::REG_FAST_GAIN, 20'd0);
    write_cfg(ocz_pkg::REG_SLOW_GAIN, 20'd0);
    write_cfg(ocz_pkg::REG_STICK_GAIN, 20'd0);
    run_phase(250, 0, 77, 5);
    write_cfg(ocz_pkg::REG_MIN_RADIUS, 20'd5120);
    write_cfg(ocz_pkg::REG_MAX_RADIUS, 20'd512000);
    write_cfg(ocz_pkg::REG_FAST_GAIN, 20'd19661);
    write_cfg(ocz_pkg::REG_SLOW_GAIN, 20'd30000);
    write_cfg(ocz_pkg::REG_STICK_GAIN, 20'd7);
    write_cfg(ocz_pkg::REG_ZOOM_RATE, 20'd2621);
    write_cfg(ocz_pkg::REG_HEIGHT_OFFSET, 20'd5120);
    run_phase(400, 28, 28, 5);
    write_cfg(ocz_pkg::REG_STICK_GAIN, 20'd15);
    run_phase(300, 0, 0, 20);
    run_phase(350, $urandom_range(10, 60), $urandom_range(10, 60), 5);

    $display("Checked %0d results, %0d of them exit frames, over several register settings",
             n_views, n_exits);
    $display("and idle, stall and back-pressure phases.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
